>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the upscaler checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define IPU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("Implication check failed.");

// The consequent must hold in the cycle after the antecedent.
`define IPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

>>> design/ipu_pkg.sv
// ---------------------------------------------------------------------------
// Upscaler package
// Shared constants, codes, types and helpers of the pixel upscaler.
// ---------------------------------------------------------------------------
package ipu_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 8;

  localparam int SCALE_W    = 4;
  localparam int WIDTH_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int PIX_CNT_W  = 5;
  localparam int PAD_CNT_W  = 2;
  localparam int SCALE_CMP_W = 5;
  localparam int WIDTH_CMP_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 2'd0,
    REG_WIDTH = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef struct packed {
    logic [RGB_W-1:0]     rgb;
    logic                 use_mem;
    logic [PIX_CNT_W-1:0] pix_left;
    logic [PAD_CNT_W-1:0] pad_left;
    logic                 row_end;
    logic                 rej;
  } job_t;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             is_pad;
    logic             eor;
    logic             rej;
    logic             last;
  } res_t;

  // Number of zero bytes that bring width * scale * 3 to a multiple of four.
  function automatic logic [PAD_CNT_W-1:0] pad_count(logic [1:0] w_lo, logic [1:0] s_lo);
    logic [3:0] prod;
    logic [1:0] bytes_lo;
    prod     = 4'(w_lo) * 4'(s_lo);
    bytes_lo = 2'(prod * 4'd3);
    return 2'(2'd0 - bytes_lo);
  endfunction

endpackage

>>> design/ipu_line_mem.sv
// ---------------------------------------------------------------------------
// Upscaler line memory
// Single-write, single-read row store with a registered read port.
// ---------------------------------------------------------------------------
module ipu_line_mem
  import ipu_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WIDTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [RGB_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [RGB_W-1:0]  rdata_o
);

  logic [RGB_W-1:0] mem_q [DEPTH];
  logic [RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ipu_emit.sv
// ---------------------------------------------------------------------------
// Upscaler result serializer
// Holds one job; unstalled, emits one result per cycle to an output register.
// ---------------------------------------------------------------------------
module ipu_emit
  import ipu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  job_t             job_i,
  input  logic [RGB_W-1:0] mem_rgb_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             res_o
);

  job_t job_q;
  logic job_valid_q;
  res_t res_q;
  logic out_valid_q;

  logic fire;
  logic cur_pix;
  res_t res_d;

  assign fire    = job_valid_q && (!out_valid_q || out_ready_i);
  assign cur_pix = (job_q.pix_left != '0);

  always_comb begin
    res_d.rej = job_q.rej;
    if (cur_pix) begin
      res_d.rgb    = job_q.use_mem ? mem_rgb_i : job_q.rgb;
      res_d.is_pad = 1'b0;
      res_d.last   = (job_q.pix_left == PIX_CNT_W'(1)) && (job_q.pad_left == '0);
    end else begin
      res_d.rgb    = '0;
      res_d.is_pad = 1'b1;
      res_d.last   = (job_q.pad_left == PAD_CNT_W'(1));
    end
    res_d.eor = res_d.last && job_q.row_end;
  end

  assign free_o = !job_valid_q || (fire && res_d.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (load_i) begin
      job_valid_q <= 1'b1;
    end else if (fire && res_d.last) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end else if (fire) begin
      if (cur_pix) begin
        job_q.pix_left <= job_q.pix_left - PIX_CNT_W'(1);
      end else begin
        job_q.pad_left <= job_q.pad_left - PAD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/integer_pixel_upscaler_top.sv
// ---------------------------------------------------------------------------
// Integer pixel upscaler
// Nearest-neighbor enlargement of 24-bit RGB rows by a whole-number factor.
// ---------------------------------------------------------------------------
// A pixel item accepted with no replay pending is written to the line memory
// and produces scale_factor copies of itself, followed at a row end by zero pad
// bytes, one result per cycle while the output is not stalled. Pixels sent
// during a replay are rejected. A replay tick gives a pad byte or a pixel read
// through the line memory's registered read port. A new item is accepted in the
// cycle the previous item's last result leaves the serializer. The line memory
// needs no clearing pass after reset. Configuration is to be written by the
// user only while the block is idle; the block does not enforce it.
module integer_pixel_upscaler_top
  import ipu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [CH_W-1:0]       red_i,
  input  logic [CH_W-1:0]       green_i,
  input  logic [CH_W-1:0]       blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o,
  output logic                  is_pad_o,
  output logic                  end_of_row_o,
  output logic                  rejected_o,
  output logic                  last_of_run_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE + 1) : 1;

  logic [SCALE_W-1:0] scale_q;
  logic [WIDTH_W-1:0] width_q;

  logic [CW-1:0]        wcol_q, wcol_d;
  logic [SW-1:0]        rows_left_q, rows_left_d;
  logic [CW-1:0]        rcol_q, rcol_d;
  logic [SW-1:0]        copy_q, copy_d;
  logic [PAD_CNT_W-1:0] pad_left_q, pad_left_d;

  logic [SW-1:0]        s_eff;
  logic [WW-1:0]        w_eff;
  logic [PAD_CNT_W-1:0] pads;
  logic                 accept;
  logic                 free;
  logic                 mem_we;
  logic                 mem_re;
  logic [RGB_W-1:0]     mem_rgb;
  logic                 job_load;
  job_t                 job;
  res_t                 res;
  logic [SW:0]          copy_inc;
  logic [PAD_CNT_W-1:0] pad_dec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
      width_q <= WIDTH_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCALE: scale_q <= SCALE_W'(cfg_data_i);
        REG_WIDTH: width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_q == '0) begin
      s_eff = SW'(1);
    end else if (SCALE_CMP_W'(scale_q) > SCALE_CMP_W'(MAX_SCALE)) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_q);
    end
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (WIDTH_CMP_W'(width_q) > WIDTH_CMP_W'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    pads = pad_count(2'(w_eff), 2'(s_eff));
  end

  assign in_ready_o = free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    wcol_d      = wcol_q;
    rows_left_d = rows_left_q;
    rcol_d      = rcol_q;
    copy_d      = copy_q;
    pad_left_d  = pad_left_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    job_load    = 1'b0;
    job         = '0;
    copy_inc    = (SW + 1)'(copy_q) + (SW + 1)'(1);
    pad_dec     = pad_left_q - PAD_CNT_W'(1);

    if (accept) begin
      if (func_i == FUNC_PIXEL) begin
        job_load = 1'b1;
        if (rows_left_q != '0) begin
          job.pix_left = PIX_CNT_W'(1);
          job.rej      = 1'b1;
        end else begin
          mem_we       = 1'b1;
          job.rgb      = {red_i, green_i, blue_i};
          job.pix_left = PIX_CNT_W'(s_eff);
          if ((WW'(wcol_q) + WW'(1)) >= w_eff) begin
            job.pad_left = pads;
            job.row_end  = 1'b1;
            wcol_d       = '0;
            rows_left_d  = s_eff - SW'(1);
            rcol_d       = '0;
            copy_d       = '0;
            pad_left_d   = '0;
          end else begin
            wcol_d = wcol_q + CW'(1);
          end
        end
      end else if (rows_left_q != '0) begin
        job_load = 1'b1;
        if (pad_left_q != '0) begin
          job.pad_left = PAD_CNT_W'(1);
          pad_left_d   = pad_dec;
          if (pad_dec == '0) begin
            job.row_end = 1'b1;
            rows_left_d = rows_left_q - SW'(1);
            rcol_d      = '0;
            copy_d      = '0;
          end
        end else begin
          mem_re       = 1'b1;
          job.use_mem  = 1'b1;
          job.pix_left = PIX_CNT_W'(1);
          if (copy_inc >= (SW + 1)'(s_eff)) begin
            copy_d = '0;
            if ((WW'(rcol_q) + WW'(1)) >= w_eff) begin
              rcol_d = '0;
              if (pads == '0) begin
                job.row_end = 1'b1;
                rows_left_d = rows_left_q - SW'(1);
                pad_left_d  = '0;
              end else begin
                pad_left_d = pads;
              end
            end else begin
              rcol_d = rcol_q + CW'(1);
            end
          end else begin
            copy_d = SW'(copy_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q      <= '0;
      rows_left_q <= '0;
      rcol_q      <= '0;
      copy_q      <= '0;
      pad_left_q  <= '0;
    end else begin
      wcol_q      <= wcol_d;
      rows_left_q <= rows_left_d;
      rcol_q      <= rcol_d;
      copy_q      <= copy_d;
      pad_left_q  <= pad_left_d;
    end
  end

  ipu_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wcol_q),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (mem_re),
    .raddr_i (rcol_q),
    .rdata_o (mem_rgb)
  );

  ipu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (job_load),
    .job_i       (job),
    .mem_rgb_i   (mem_rgb),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign out_red_o     = res.rgb[RGB_W-1 -: CH_W];
  assign out_green_o   = res.rgb[CH_W +: CH_W];
  assign out_blue_o    = res.rgb[CH_W-1:0];
  assign is_pad_o      = res.is_pad;
  assign end_of_row_o  = res.eor;
  assign rejected_o    = res.rej;
  assign last_of_run_o = res.last;

endmodule

>>> design/ipu_checker.sv
// ---------------------------------------------------------------------------
// Upscaler port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ipu_checker
  import ipu_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [CH_W-1:0] out_red_o,
  input logic [CH_W-1:0] out_green_o,
  input logic [CH_W-1:0] out_blue_o,
  input logic            is_pad_o,
  input logic            end_of_row_o,
  input logic            rejected_o,
  input logic            last_of_run_o
);

  `IPU_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, out_valid_o && (is_pad_o || rejected_o), (out_red_o == '0) && (out_green_o == '0) && (out_blue_o == '0))
  `IPU_ASSERT_IMPL(a_rej_alone, clk_i, rst_ni, out_valid_o && rejected_o, last_of_run_o && !is_pad_o && !end_of_row_o)
  `IPU_ASSERT_IMPL(a_eor_last, clk_i, rst_ni, out_valid_o && end_of_row_o, last_of_run_o)
  `IPU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_red_o) && $stable(is_pad_o) && $stable(last_of_run_o))

endmodule

bind integer_pixel_upscaler_top ipu_checker u_ipu_checker (.*);

>>> tb/sv/upscale_check_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Upscaler checker
// Tracks the line memory, replay position and registers of the upscaler,
// predicts the results of every accepted item, and compares each result
// leaving the block with the oldest prediction.
// ---------------------------------------------------------------------------
package upscale_check_pkg;
  import ipu_pkg::*;

  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int TOP_SCALE  = DEF_MAX_SCALE;

  typedef struct {
    bit [CH_W-1:0] red;
    bit [CH_W-1:0] green;
    bit [CH_W-1:0] blue;
    bit            pad;
    bit            eor;
    bit            rej;
    bit            last;
  } pixel_out_t;

  class upscale_checker;
    bit [RGB_W-1:0]   line_mem [LINE_DEPTH];
    int unsigned      wr_col;
    int unsigned      rows_left;
    int unsigned      rep_col;
    int unsigned      rep_copy;
    int unsigned      pad_left;
    bit [SCALE_W-1:0] scale_reg;
    bit [WIDTH_W-1:0] width_reg;
    pixel_out_t       expected_q[$];
    int unsigned      errors;
    int unsigned      results;
    int unsigned      rejects;
    int unsigned      pads;
    int unsigned      cfg_writes;

    function new();
      scale_reg = 1;
      width_reg = 1;
    endfunction

    function int unsigned scale_now();
      if (scale_reg == 0) return 1;
      if (scale_reg > TOP_SCALE) return TOP_SCALE;
      return scale_reg;
    endfunction

    function int unsigned width_now();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned pad_bytes();
      int unsigned nbytes;
      nbytes = width_now() * scale_now() * 3;
      return (4 - nbytes % 4) % 4;
    endfunction

    function void push(bit [RGB_W-1:0] rgb, bit pad, bit eor, bit rej, bit last);
      pixel_out_t e;
      e.red   = rgb[23:16];
      e.green = rgb[15:8];
      e.blue  = rgb[7:0];
      e.pad   = pad;
      e.eor   = eor;
      e.rej   = rej;
      e.last  = last;
      expected_q.push_back(e);
    endfunction

    function void end_replay_row();
      if (rows_left > 0) rows_left--;
      rep_col  = 0;
      rep_copy = 0;
      pad_left = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [CFG_DATA_W-1:0] data);
      cfg_writes++;
      case (idx)
        REG_SCALE: scale_reg = data[SCALE_W-1:0];
        REG_WIDTH: width_reg = data[WIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    // Returns the number of results the item causes.
    function int unsigned note_item(func_e fn, bit [CH_W-1:0] r, bit [CH_W-1:0] g,
                                    bit [CH_W-1:0] b);
      int unsigned s;
      int unsigned w;
      int unsigned col;
      int unsigned npad;
      int unsigned total;
      int unsigned copy;
      int unsigned k;
      bit row_end;
      bit eor;
      bit [RGB_W-1:0] rgb;
      s = scale_now();
      w = width_now();
      if (fn == FUNC_PIXEL) begin
        if (rows_left != 0) begin
          push(0, 0, 0, 1, 1);
          rejects++;
          return 1;
        end
        rgb = {r, g, b};
        col = wr_col % LINE_DEPTH;
        row_end = (col + 1 >= w);
        npad = row_end ? pad_bytes() : 0;
        total = s + npad;
        line_mem[col] = rgb;
        for (k = 0; k < s; k++) begin
          push(rgb, 0, row_end && (k + 1 == total), 0, k + 1 == total);
        end
        for (k = s; k < total; k++) begin
          push(0, 1, k + 1 == total, 0, k + 1 == total);
        end
        pads += npad;
        if (row_end) begin
          wr_col    = 0;
          rows_left = s - 1;
          rep_col   = 0;
          rep_copy  = 0;
          pad_left  = 0;
        end else begin
          wr_col = col + 1;
        end
        return total;
      end
      if (rows_left == 0) return 0;
      if (pad_left != 0) begin
        pad_left--;
        pads++;
        if (pad_left == 0) begin
          push(0, 1, 1, 0, 1);
          end_replay_row();
        end else begin
          push(0, 1, 0, 0, 1);
        end
        return 1;
      end
      col  = rep_col % LINE_DEPTH;
      rgb  = line_mem[col];
      copy = rep_copy + 1;
      eor  = 0;
      if (copy >= s) begin
        rep_copy = 0;
        if (col + 1 >= w) begin
          npad = pad_bytes();
          rep_col = 0;
          if (npad == 0) begin
            eor = 1;
            end_replay_row();
          end else begin
            pad_left = npad;
          end
        end else begin
          rep_col = col + 1;
        end
      end else begin
        rep_copy = copy;
      end
      push(rgb, 0, eor, 0, 1);
      return 1;
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(bit [CH_W-1:0] r, bit [CH_W-1:0] g, bit [CH_W-1:0] b,
                               bit pad, bit eor, bit rej, bit last);
      pixel_out_t e;
      results++;
      if (expected_q.size() == 0) begin
        $error("Unexpected result: rgb %0d/%0d/%0d pad %0b eor %0b rej %0b last %0b",
               r, g, b, pad, eor, rej, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("out_red", e.red, r);
      compare("out_green", e.green, g);
      compare("out_blue", e.blue, b);
      compare("is_pad", e.pad, pad);
      compare("end_of_row", e.eor, eor);
      compare("rejected", e.rej, rej);
      compare("last_of_run", e.last, last);
    endfunction

    function void check_leftover();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Upscaler testbench
// Drives pixel and replay tick items through the integer upscaler under
// several scale and width settings and idle profiles, and checks every
// result against a cycle-independent prediction of the block.
// ---------------------------------------------------------------------------
module tb_top;
  import ipu_pkg::*;
  import upscale_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TARGET_ITEMS   = 480;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  func_i      = 1'b0;
  logic [CH_W-1:0]       red_i       = '0;
  logic [CH_W-1:0]       green_i     = '0;
  logic [CH_W-1:0]       blue_i      = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CH_W-1:0]       out_red_o;
  logic [CH_W-1:0]       out_green_o;
  logic [CH_W-1:0]       out_blue_o;
  logic                  is_pad_o;
  logic                  end_of_row_o;
  logic                  rejected_o;
  logic                  last_of_run_o;

  upscale_checker pixel_check;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    counted_items  = 0;
  int unsigned    idle_cycles    = 0;

  integer_pixel_upscaler_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .is_pad_o      (is_pad_o),
    .end_of_row_o  (end_of_row_o),
    .rejected_o    (rejected_o),
    .last_of_run_o (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      pixel_check.check_result(out_red_o, out_green_o, out_blue_o, is_pad_o,
                               end_of_row_o, rejected_o, last_of_run_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_check.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(func_e fn, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    int unsigned n;
    if ($urandom_range(0, 99) < 3) wait_drained();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    n = pixel_check.note_item(fn, r, g, b);
    if (n > 0) counted_items++;
  endtask

  task automatic send_pixel();
    send_item(FUNC_PIXEL, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  task automatic finish_replays();
    while (pixel_check.rows_left != 0) send_tick();
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    pixel_check.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_scale(int unsigned s);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[SCALE_W-1:0] = SCALE_W'(s);
    write_cfg(REG_SCALE, d);
  endtask

  task automatic run_directed();
    send_item(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_tick();
    set_scale(0);
    write_cfg(REG_WIDTH, 11'h7FF);
    send_item(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_item(FUNC_PIXEL, 8'h00, 8'hFF, 8'h00);
    // Shrinking the width below the open column ends the row on the next pixel.
    write_cfg(REG_WIDTH, 11'd2);
    send_item(FUNC_PIXEL, 8'h0F, 8'hF0, 8'h81);
    set_scale(15);
    write_cfg(REG_WIDTH, 11'd0);
    send_item(FUNC_PIXEL, 8'h5A, 8'hA5, 8'h3C);
    send_item(FUNC_PIXEL, 8'h7E, 8'h01, 8'h80);
    repeat (3) send_tick();
    set_scale(1);
    finish_replays();
  endtask

  task automatic run_random_phase(int unsigned mode);
    int unsigned s_raw;
    int unsigned w_raw;
    int unsigned pick;
    int unsigned rows;
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 88;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 88;
      end
      default: begin
        send_idle_pct = 8;
        recv_stall_pct = 8;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 5) s_raw = 0;
    else if (pick < 20) s_raw = $urandom_range(5, 15);
    else s_raw = $urandom_range(1, 4);
    pick = $urandom_range(0, 99);
    if (pick < 10) w_raw = 0;
    else if (s_raw >= 5) w_raw = $urandom_range(1, 2);
    else if (s_raw <= 2 && pick < 30) w_raw = $urandom_range(7, 24);
    else w_raw = $urandom_range(1, 6);
    if ($urandom_range(0, 1) == 0) begin
      set_scale(s_raw);
      write_cfg(REG_WIDTH, CFG_DATA_W'(w_raw));
    end else begin
      write_cfg(REG_WIDTH, CFG_DATA_W'(w_raw));
      set_scale(s_raw);
    end
    rows = $urandom_range(1, 3);
    repeat (rows) begin
      if (counted_items >= TARGET_ITEMS) break;
      do begin
        if ($urandom_range(0, 99) < 8) send_tick();
        send_pixel();
      end while (pixel_check.wr_col != 0);
      while (pixel_check.rows_left != 0) begin
        if ($urandom_range(0, 99) < 6) send_pixel();
        else send_tick();
      end
    end
    if ($urandom_range(0, 99) < 35) begin
      repeat ($urandom_range(0, pixel_check.width_now() - 1)) send_pixel();
    end
  endtask

  initial begin
    int unsigned phase;
    pixel_check = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    phase = 0;
    while (counted_items < TARGET_ITEMS) begin
      run_random_phase(phase % 4);
      phase++;
    end
    in_valid_i <= 1'b0;
    while (pixel_check.expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    pixel_check.check_leftover();
    $display("Run covered %0d result-producing items in %0d random phases, %0d results,",
             counted_items, phase, pixel_check.results);
    $display("%0d writes, %0d rejected pixels and %0d pad bytes under four idle profiles.",
             pixel_check.cfg_writes, pixel_check.rejects, pixel_check.pads);
    if (pixel_check.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
